// ----- rtl/bphc_pkg.sv -----
// bphc_pkg: types and constants shared by the button press/hold classifier
// no dependencies; imported by every module of the block

package bphc_pkg;

    localparam int SLOTS       = 8;     // buttons carried by the stream fields
    localparam int CNT_W       = 16;
    localparam int CLS_W       = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_DATA_W   = 8;
    localparam int OUT_FIELD_W = SLOTS * CLS_W;
    localparam int OUT_DATA_W  = 2 * OUT_FIELD_W;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // press class of one button, also the code of a release event
    typedef enum logic [CLS_W-1:0] {
        CLS_NONE    = 2'd0,
        CLS_PRESSED = 2'd1,
        CLS_HOLD    = 2'd2,
        CLS_LONG    = 2'd3
    } t_class;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE  = 2'd0,
        REG_HOLD      = 2'd1,
        REG_LONG_HOLD = 2'd2,
        REG_UNUSED    = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [CNT_W-1:0] debounce;
        logic [CNT_W-1:0] hold;
        logic [CNT_W-1:0] long_hold;
    } t_thresh;

    localparam logic [CNT_W-1:0] DEBOUNCE_RST  = 16'd20;
    localparam logic [CNT_W-1:0] HOLD_RST      = 16'd1000;
    localparam logic [CNT_W-1:0] LONG_HOLD_RST = 16'd3000;

endpackage

// ----- rtl/bphc_cfg.sv -----
// bphc_cfg: threshold registers written through the plain write port
// depends on bphc_pkg

module bphc_cfg
    import bphc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_thresh               o_thresh
);

    t_thresh r_thresh;
    t_thresh n_thresh;

    always_comb begin
        n_thresh = r_thresh;
        if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                REG_DEBOUNCE:  n_thresh.debounce  = i_cfg_data;
                REG_HOLD:      n_thresh.hold      = i_cfg_data;
                REG_LONG_HOLD: n_thresh.long_hold = i_cfg_data;
                default:       n_thresh = r_thresh;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh.debounce  <= DEBOUNCE_RST;
            r_thresh.hold      <= HOLD_RST;
            r_thresh.long_hold <= LONG_HOLD_RST;
        end else begin
            r_thresh <= n_thresh;
        end
    end

    assign o_thresh = r_thresh;

endmodule

// ----- rtl/bphc_btn.sv -----
// bphc_btn: state of one button (level, press counter, class) and its update per tick
// depends on bphc_pkg

module bphc_btn
    import bphc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_level,
    input  t_thresh i_thresh,
    output t_class  o_release,
    output t_class  o_class
);

    logic             r_last;
    logic [CNT_W-1:0] r_cnt;
    t_class           r_class;

    logic             n_last;
    logic [CNT_W-1:0] n_cnt;
    t_class           n_class;
    t_class           w_release;
    logic [CNT_W-1:0] w_cnt_up;

    // saturating increment
    assign w_cnt_up = (r_cnt == CNT_MAX) ? r_cnt : r_cnt + 1'b1;

    always_comb begin
        n_last    = r_last;
        n_cnt     = r_cnt;
        n_class   = r_class;
        w_release = CLS_NONE;
        if (i_level == r_last) begin
            if (i_level) begin
                n_cnt = w_cnt_up;
                if (w_cnt_up == i_thresh.debounce) begin
                    if (r_class == CLS_NONE) begin
                        n_class = CLS_PRESSED;
                    end
                end else if (w_cnt_up == i_thresh.hold) begin
                    n_class = CLS_HOLD;
                end else if (w_cnt_up == i_thresh.long_hold) begin
                    n_class = CLS_LONG;
                end
            end
        end else begin
            n_last = i_level;
            // a change with no class keeps the counter
            if (r_class != CLS_NONE) begin
                w_release = r_class;
                n_last    = 1'b0;
                n_cnt     = '0;
                n_class   = CLS_NONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last  <= 1'b0;
            r_cnt   <= '0;
            r_class <= CLS_NONE;
        end else if (i_en) begin
            r_last  <= n_last;
            r_cnt   <= n_cnt;
            r_class <= n_class;
        end
    end

    assign o_release = w_release;
    assign o_class   = n_class;

endmodule

// ----- rtl/button_press_hold_classifier_unit.sv -----
// button_press_hold_classifier_unit: top level, input register, per-button cells,
// result register; depends on bphc_pkg, bphc_cfg, bphc_btn
//
//  channel   | dir | handshake                   | payload
//  s_axis    | in  | s_axis_tvalid/s_axis_tready | tdata[7:0]   button_levels
//  m_axis    | out | m_axis_tvalid/m_axis_tready | tdata[15:0]  release_events,
//            |     |                             | tdata[31:16] current_classes
//  cfg write | in  | i_cfg_we                    | i_cfg_index, i_cfg_data
//
// one tick per cycle sustained while the output is not stalled; a tick passes the input register,
// then per-button compare/update into the result register
// synchronous active-low reset clears button state and restores default thresholds
// a stalled output holds its result; the input register still takes one more tick

module button_press_hold_classifier_unit
    import bphc_pkg::*;
#(
    parameter int NUM_BUTTONS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [7:0] button_levels
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [15:0] release_events, [31:16] current_classes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int NB = (NUM_BUTTONS < SLOTS) ? NUM_BUTTONS : SLOTS;

    logic                  r_in_valid;
    logic [IN_DATA_W-1:0]  r_in_levels;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic                   w_advance;
    logic                   w_in_xfer;
    t_thresh                w_thresh;
    logic [OUT_FIELD_W-1:0] w_rel;
    logic [OUT_FIELD_W-1:0] w_cur;
    logic [SLOTS-1:0]       w_rel_ok;

    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;

    bphc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_thresh    (w_thresh)
    );

    for (genvar k = 0; k < SLOTS; k++) begin : g_btn
        if (k < NB) begin : g_on
            t_class w_release;
            t_class w_class;

            bphc_btn u_btn (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_en      (w_advance),
                .i_level   (r_in_levels[k]),
                .i_thresh  (w_thresh),
                .o_release (w_release),
                .o_class   (w_class)
            );

            assign w_rel[CLS_W*k +: CLS_W] = w_release;
            assign w_cur[CLS_W*k +: CLS_W] = w_class;
        end else begin : g_off
            assign w_rel[CLS_W*k +: CLS_W] = CLS_NONE;
            assign w_cur[CLS_W*k +: CLS_W] = CLS_NONE;
        end
        // a released button must report class none in the same result
        assign w_rel_ok[k] = (r_out_data[CLS_W*k +: CLS_W] == CLS_NONE)
                          || (r_out_data[OUT_FIELD_W + CLS_W*k +: CLS_W] == CLS_NONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_in_levels <= s_axis_tdata;
        end
        if (w_advance) begin
            r_out_data <= {w_cur, w_rel};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_advance_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("result register not loaded after an advance");

    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_in_levels)))
        else $error("pending tick lost while output stalled");

    a_release_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (&w_rel_ok))
        else $error("released button still shows a class");

endmodule

// ----- tb/testbench.sv -----
// testbench for button_press_hold_classifier_unit: directed and random tick streams,
// a per-button press/hold predictor and an in-order result checker
// depends on bphc_pkg and the rtl of the classifier

module testbench
    import bphc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_BUTTONS = 8;
    localparam int BTN_CNT     = (NUM_BUTTONS < SLOTS) ? NUM_BUTTONS : SLOTS;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 8;

    // packed from the top bit down: current_classes sits above release_events
    typedef struct packed {
        logic [OUT_FIELD_W-1:0] classes;
        logic [OUT_FIELD_W-1:0] releases;
    } t_tick_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // predictor state
    t_thresh          thr;
    logic             lvl_q [SLOTS];
    logic [CNT_W-1:0] cnt_q [SLOTS];
    t_class           cls_q [SLOTS];

    t_tick_result tick_results_q [$];
    int           fail_cnt = 0;
    int           cycle_cnt = 0;
    int           idle_pct = 7;
    int           stall_pct = 7;

    // random level generator, one run length per button
    logic gen_lvl  [SLOTS];
    int   gen_left [SLOTS];

    button_press_hold_classifier_unit #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch %s: got %h expected %h", $realtime, what, got, want);
        fail_cnt++;
    endtask

    // result checker, in order against the oldest prediction
    always @(posedge i_clk) begin
        t_tick_result got;
        t_tick_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (tick_results_q.size() == 0) begin
                report_mismatch("unexpected transfer", m_axis_tdata, '0);
            end else begin
                want = tick_results_q.pop_front();
                if (got.releases !== want.releases)
                    report_mismatch("release_events", 32'(got.releases),
                                    32'(want.releases));
                if (got.classes !== want.classes)
                    report_mismatch("current_classes", 32'(got.classes),
                                    32'(want.classes));
            end
        end
    end

    function automatic void reset_predictor();
        thr.debounce  = DEBOUNCE_RST;
        thr.hold      = HOLD_RST;
        thr.long_hold = LONG_HOLD_RST;
        for (int b = 0; b < SLOTS; b++) begin
            lvl_q[b] = 1'b0;
            cnt_q[b] = '0;
            cls_q[b] = CLS_NONE;
        end
    endfunction

    function automatic t_tick_result classify_tick(input logic [IN_DATA_W-1:0] levels);
        t_tick_result res;
        res = '0;
        for (int b = 0; b < BTN_CNT; b++) begin
            if (levels[b] == lvl_q[b]) begin
                if (levels[b]) begin
                    if (cnt_q[b] != CNT_MAX)
                        cnt_q[b] = cnt_q[b] + 1'b1;
                    // priority chain, the first equal threshold wins
                    if (cnt_q[b] == thr.debounce) begin
                        if (cls_q[b] == CLS_NONE)
                            cls_q[b] = CLS_PRESSED;
                    end else if (cnt_q[b] == thr.hold) begin
                        cls_q[b] = CLS_HOLD;
                    end else if (cnt_q[b] == thr.long_hold) begin
                        cls_q[b] = CLS_LONG;
                    end
                end
            end else begin
                lvl_q[b] = levels[b];
                // a change with no class keeps the counter
                if (cls_q[b] != CLS_NONE) begin
                    res.releases[2*b +: 2] = cls_q[b];
                    lvl_q[b] = 1'b0;
                    cnt_q[b] = '0;
                    cls_q[b] = CLS_NONE;
                end
            end
            res.classes[2*b +: 2] = cls_q[b];
        end
        return res;
    endfunction

    task automatic send_tick(input logic [IN_DATA_W-1:0] levels);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= levels;
        do @(posedge i_clk); while (!s_axis_tready);
        tick_results_q.push_back(classify_tick(levels));
    endtask

    task automatic send_run(input logic [IN_DATA_W-1:0] levels, input int count);
        repeat (count) send_tick(levels);
    endtask

    // registers change only with the block drained and idle
    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (tick_results_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            REG_DEBOUNCE:  thr.debounce  = value;
            REG_HOLD:      thr.hold      = value;
            REG_LONG_HOLD: thr.long_hold = value;
            default: ;
        endcase
    endtask

    task automatic set_thresholds(input logic [CNT_W-1:0] deb, input logic [CNT_W-1:0] hld,
                                  input logic [CNT_W-1:0] lng);
        write_reg(REG_DEBOUNCE, deb);
        write_reg(REG_HOLD, hld);
        write_reg(REG_LONG_HOLD, lng);
    endtask

    task automatic test_reset_defaults();
        // pressed at the 20th counted tick after the rising change
        send_run(8'h01, 22);
        send_tick(8'h00);
        send_tick(8'hFF);
        send_tick(8'h00);
    endtask

    task automatic test_threshold_extremes();
        write_reg(REG_UNUSED, 16'($urandom));
        set_thresholds(16'd1, 16'd2, 16'd3);
        send_run(8'h0F, 5);
        send_tick(8'h00);
        send_tick(8'hAA);
        send_run(8'h55, 3);
        send_tick(8'h00);
        set_thresholds(16'd1, 16'd1, 16'd1);
        send_run(8'hF0, 3);
        send_tick(8'h00);
        // zero debounce never matches, hold takes over
        set_thresholds(16'd0, 16'd2, 16'd0);
        send_run(8'h81, 4);
        send_tick(8'h00);
        set_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_run(8'h3C, 3);
        send_tick(8'h00);
        write_reg(REG_UNUSED, 16'hFFFF);
    endtask

    task automatic test_long_hold();
        set_thresholds(16'd3, 16'd20, 16'd45);
        // buttons 0..6 held through hold and long hold, button 7 toggles at random
        for (int k = 0; k < 60; k++)
            send_tick({1'($urandom), 7'h7F});
        send_run(8'h00, 2);
    endtask

    function automatic logic [IN_DATA_W-1:0] next_levels(input int run_max);
        logic [IN_DATA_W-1:0] lv;
        for (int b = 0; b < SLOTS; b++) begin
            if (gen_left[b] <= 0) begin
                gen_lvl[b]  = ~gen_lvl[b];
                gen_left[b] = $urandom_range(run_max, 1);
            end
            gen_left[b]--;
            lv[b] = gen_lvl[b];
        end
        // occasional noise tick
        if ($urandom_range(99) < 10)
            lv = lv ^ IN_DATA_W'($urandom);
        return lv;
    endfunction

    task automatic test_random_presses(input int n_ticks);
        logic [CNT_W-1:0] deb;
        logic [CNT_W-1:0] hld;
        logic [CNT_W-1:0] lng;
        int               run_max;
        int               per_phase;
        per_phase = n_ticks / 6;
        for (int b = 0; b < SLOTS; b++) begin
            gen_lvl[b]  = 1'b0;
            gen_left[b] = 0;
        end
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin deb = 16'd2; hld = 16'd5; lng = 16'd9; end
                1: begin deb = 16'd4; hld = 16'd4; lng = 16'd10; end
                2: begin deb = 16'd9; hld = 16'd6; lng = 16'd3; end
                default: begin
                    deb = CNT_W'($urandom_range(8, 0));
                    hld = CNT_W'($urandom_range(20, 1));
                    lng = CNT_W'($urandom_range(40, 1));
                end
            endcase
            set_thresholds(deb, hld, lng);
            run_max = int'((deb > hld) ? deb : hld);
            run_max = ((run_max > int'(lng)) ? run_max : int'(lng)) + 4;
            // one phase with no gaps on either side
            idle_pct  = (ph == 3) ? 0 : 7;
            stall_pct = (ph == 3) ? 0 : 7;
            repeat (per_phase) send_tick(next_levels(run_max));
        end
        idle_pct  = 7;
        stall_pct = 7;
    endtask

    initial begin
        reset_predictor();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_threshold_extremes();
        test_long_hold();
        test_random_presses(400);

        s_axis_tvalid <= 1'b0;
        while (tick_results_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/bphc_pkg.sv
rtl/bphc_cfg.sv
rtl/bphc_btn.sv
rtl/button_press_hold_classifier_unit.sv
tb/testbench.sv
